FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/flt_pkg.sv
// ----------------------------------------------------------------------------
// flt_pkg
// Shared types, codes and helper functions of the flow totalizer.
// ----------------------------------------------------------------------------
package flt_pkg;

    // Width of the window and total accumulators.
    localparam int CountBits = 32;
    localparam int CmpBits   = (CountBits > 32) ? CountBits : 32;

    // Depth of the queue between front and back.
    localparam int QDepth   = 4;
    localparam int QPtrBits = $clog2(QDepth);
    localparam int QCntBits = $clog2(QDepth + 1);

    // Event kinds.
    localparam logic [1:0] EvFlow   = 2'd0;
    localparam logic [1:0] EvThresh = 2'd1;
    localparam logic [1:0] EvPress  = 2'd2;

    // Alarm levels.
    localparam logic [2:0] AlarmNone  = 3'd0;
    localparam logic [2:0] AlarmWarn1 = 3'd1;
    localparam logic [2:0] AlarmWarn2 = 3'd2;
    localparam logic [2:0] AlarmWarn3 = 3'd3;
    localparam logic [2:0] AlarmLimit = 3'd4;

    // Register indexes.
    localparam logic [2:0] RegWindowTicks   = 3'd0;
    localparam logic [2:0] RegDebounceTicks = 3'd1;
    localparam logic [2:0] RegHoldoffTicks  = 3'd2;
    localparam logic [2:0] RegWarn1         = 3'd3;
    localparam logic [2:0] RegWarn2         = 3'd4;
    localparam logic [2:0] RegWarn3         = 3'd5;
    localparam logic [2:0] RegLimit         = 3'd6;

    typedef struct packed {
        logic [15:0] window_ticks;
        logic [15:0] debounce_ticks;
        logic [15:0] holdoff_ticks;
        logic [31:0] warn1;
        logic [31:0] warn2;
        logic [31:0] warn3;
        logic [31:0] limit;
    } t_cfg;

    // One tick's worth of events, handed from front to back.
    typedef struct packed {
        logic                 flow;
        logic                 press;
        logic [CountBits-1:0] wcount;
        logic [16:0]          wlength;
        logic [CountBits-1:0] total;
        logic [2:0]           state;
    } t_rec;

    function automatic logic [15:0] inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [CountBits-1:0] sat_cnt(input logic [CountBits+1:0] s);
        if (s > {2'b00, {CountBits{1'b1}}}) begin
            return {CountBits{1'b1}};
        end
        return s[CountBits-1:0];
    endfunction

    function automatic logic [31:0] low32(input logic [CountBits-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[31:0];
    endfunction

    // Four-level ladder, first match wins.
    function automatic logic [2:0] ladder(input logic [CountBits-1:0] total,
                                          input logic [2:0] st, input t_cfg cfg);
        logic [CmpBits-1:0] t, w1, w2, w3, lm;
        t  = CmpBits'(total);
        w1 = CmpBits'(cfg.warn1);
        w2 = CmpBits'(cfg.warn2);
        w3 = CmpBits'(cfg.warn3);
        lm = CmpBits'(cfg.limit);
        if (t >= w1 && t < w2 && st < 3'd1) begin
            return AlarmWarn1;
        end else if (t >= w2 && t < w3 && st < 3'd2) begin
            return AlarmWarn2;
        end else if (t >= w3 && t < lm && st < 3'd3) begin
            return AlarmWarn3;
        end else if (t >= lm && st < 3'd4) begin
            return AlarmLimit;
        end
        return AlarmNone;
    endfunction

endpackage

FILE: hdl/flt_if.sv
// ----------------------------------------------------------------------------
// flt_if
// Valid/ready channels of the flow totalizer: tick input, event output and
// configuration write.
// ----------------------------------------------------------------------------
interface flt_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] pulse_inc;
    logic       button_level;
    logic [2:0] system_state;

    modport source (output valid, output pulse_inc, output button_level,
                    output system_state, input ready);
    modport sink   (input valid, input pulse_inc, input button_level,
                    input system_state, output ready);
endinterface

interface flt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [2:0]  alarm_level;
    logic [31:0] window_count;
    logic [16:0] window_length;
    logic [31:0] total_count;
    logic        last;

    modport source (output valid, output event_kind, output alarm_level,
                    output window_count, output window_length, output total_count,
                    output last, input ready);
    modport sink   (input valid, input event_kind, input alarm_level,
                    input window_count, input window_length, input total_count,
                    input last, output ready);
endinterface

interface flt_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  addr;
    logic [31:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

FILE: hdl/flt_front.sv
// ----------------------------------------------------------------------------
// flt_front
// Tick front end: advance timers, accumulate pulses, debounce the button
// and push a record for every tick that raises at least one event.
// ----------------------------------------------------------------------------
module flt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    flt_in_if.sink            i_tick,
    input  flt_pkg::t_cfg     i_cfg,
    input  logic              i_q_full,
    output logic              o_push,
    output flt_pkg::t_rec     o_rec
);

    logic [flt_pkg::CountBits-1:0] r_win, n_win;
    logic [flt_pkg::CountBits-1:0] r_tot, n_tot;
    logic [16:0]                   r_elapsed, n_elapsed;
    logic [15:0]                   r_stable, n_stable;
    logic [15:0]                   r_since, n_since;
    logic                          r_prev, r_deb, n_deb;

    logic                          accept;
    logic [16:0]                   elapsed_inc;
    logic [15:0]                   since_inc;
    logic [flt_pkg::CountBits-1:0] win_inc, tot_flow;
    logic                          flow, deb_chg, press;

    assign i_tick.ready = !i_q_full;
    assign accept       = i_tick.valid && !i_q_full;

    always_comb begin
        since_inc   = flt_pkg::inc16(r_since);
        elapsed_inc = (r_elapsed < 17'h10000) ? r_elapsed + 17'd1 : r_elapsed;
        win_inc     = flt_pkg::sat_cnt({2'b00, r_win}
                                       + (flt_pkg::CountBits + 2)'(i_tick.pulse_inc));
        // Total plus window plus this tick, saturated once: same as two
        // saturating adds since every term is non-negative.
        tot_flow    = flt_pkg::sat_cnt({2'b00, r_tot} + {2'b00, r_win}
                                       + (flt_pkg::CountBits + 2)'(i_tick.pulse_inc));
        flow        = elapsed_inc > {1'b0, i_cfg.window_ticks};

        n_stable    = (i_tick.button_level != r_prev) ? 16'd0 : flt_pkg::inc16(r_stable);
        deb_chg     = (n_stable > i_cfg.debounce_ticks) && (i_tick.button_level != r_deb);
        press       = deb_chg && !i_tick.button_level && (since_inc > i_cfg.holdoff_ticks);

        n_since     = press ? 16'd0 : since_inc;
        n_elapsed   = flow ? 17'd0 : elapsed_inc;
        n_win       = (flow || press) ? '0 : win_inc;
        n_tot       = press ? '0 : (flow ? tot_flow : r_tot);
        n_deb       = deb_chg ? i_tick.button_level : r_deb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win     <= '0;
            r_tot     <= '0;
            r_elapsed <= '0;
            r_stable  <= '0;
            r_since   <= '0;
            r_prev    <= 1'b1;
            r_deb     <= 1'b1;
        end else if (accept) begin
            r_win     <= n_win;
            r_tot     <= n_tot;
            r_elapsed <= n_elapsed;
            r_stable  <= n_stable;
            r_since   <= n_since;
            r_prev    <= i_tick.button_level;
            r_deb     <= n_deb;
        end
    end

    // Drop quiet ticks; queue the rest.
    assign o_push        = accept && (flow || press);
    assign o_rec.flow    = flow;
    assign o_rec.press   = press;
    assign o_rec.wcount  = win_inc;
    assign o_rec.wlength = elapsed_inc;
    assign o_rec.total   = tot_flow;
    assign o_rec.state   = i_tick.system_state;

endmodule

FILE: hdl/flt_queue.sv
// ----------------------------------------------------------------------------
// flt_queue
// Short register queue of tick records between front and back.
// ----------------------------------------------------------------------------
module flt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  flt_pkg::t_rec i_data,
    output logic          o_full,
    input  logic          i_pop,
    output flt_pkg::t_rec o_data,
    output logic          o_empty
);

    flt_pkg::t_rec                  r_mem [flt_pkg::QDepth];
    logic [flt_pkg::QPtrBits-1:0]   r_wr, r_rd;
    logic [flt_pkg::QCntBits-1:0]   r_cnt;
    logic                           do_push, do_pop;

    assign o_full  = (r_cnt == flt_pkg::QCntBits'(flt_pkg::QDepth));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    function automatic logic [flt_pkg::QPtrBits-1:0] bump(
            input logic [flt_pkg::QPtrBits-1:0] p);
        return (p == flt_pkg::QPtrBits'(flt_pkg::QDepth - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= bump(r_wr);
            end
            if (do_pop) begin
                r_rd <= bump(r_rd);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: hdl/flt_back.sv
// ----------------------------------------------------------------------------
// flt_back
// Event back end: expand each tick record into its flow, threshold and
// press words and send them out one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module flt_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  flt_pkg::t_cfg i_cfg,
    input  logic          i_q_empty,
    input  flt_pkg::t_rec i_q_data,
    output logic          o_pop,
    flt_out_if.source     o_event
);

    flt_pkg::t_rec r_rec;
    logic [2:0]    r_lvl, head_lvl;
    // Pending words: bit 0 flow, bit 1 threshold, bit 2 press.
    logic [2:0]    r_pend, n_pend, sel, pend_after;
    logic          emit, load;

    logic          r_ov;
    logic [1:0]    r_kind;
    logic [2:0]    r_level;
    logic [31:0]   r_wc, r_total;
    logic [16:0]   r_wl;
    logic          r_last;

    always_comb begin
        if (r_pend[0]) begin
            sel = 3'b001;
        end else if (r_pend[1]) begin
            sel = 3'b010;
        end else begin
            sel = 3'b100;
        end
        pend_after = r_pend & ~sel;
        emit       = (r_pend != 3'b000) && (!r_ov || o_event.ready);
        load       = !i_q_empty && ((r_pend == 3'b000) || (emit && pend_after == 3'b000));
        head_lvl   = flt_pkg::ladder(i_q_data.total, i_q_data.state, i_cfg);
        if (load) begin
            n_pend = {i_q_data.press, i_q_data.flow && (head_lvl != flt_pkg::AlarmNone),
                      i_q_data.flow};
        end else if (emit) begin
            n_pend = pend_after;
        end else begin
            n_pend = r_pend;
        end
    end

    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 3'b000;
            r_ov   <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_event.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec <= i_q_data;
            r_lvl <= head_lvl;
        end
        if (emit) begin
            r_last <= (pend_after == 3'b000);
            case (sel)
                3'b001: begin
                    r_kind  <= flt_pkg::EvFlow;
                    r_level <= flt_pkg::AlarmNone;
                    r_wc    <= flt_pkg::low32(r_rec.wcount);
                    r_wl    <= r_rec.wlength;
                    r_total <= flt_pkg::low32(r_rec.total);
                end
                3'b010: begin
                    r_kind  <= flt_pkg::EvThresh;
                    r_level <= r_lvl;
                    r_wc    <= '0;
                    r_wl    <= '0;
                    r_total <= flt_pkg::low32(r_rec.total);
                end
                default: begin
                    r_kind  <= flt_pkg::EvPress;
                    r_level <= flt_pkg::AlarmNone;
                    r_wc    <= '0;
                    r_wl    <= '0;
                    r_total <= '0;
                end
            endcase
        end
    end

    assign o_event.valid         = r_ov;
    assign o_event.event_kind    = r_kind;
    assign o_event.alarm_level   = r_level;
    assign o_event.window_count  = r_wc;
    assign o_event.window_length = r_wl;
    assign o_event.total_count   = r_total;
    assign o_event.last          = r_last;

endmodule

FILE: hdl/flow_totalizer_with_alarms.sv
// ----------------------------------------------------------------------------
// flow_totalizer_with_alarms
// Pulse flow totalizer with a windowed count, a four-level threshold ladder
// and a debounced reset button.
// ----------------------------------------------------------------------------
// One tick word on i_tick carries the sensor pulses of one millisecond, the
// raw button level and the system alarm state. The front end takes a tick
// every cycle while its four-entry record queue has room, and answers it with
// zero to three event words on o_event, in the order flow, threshold, press,
// with last set on the final word of the tick. The single output port sends
// one event word per cycle while o_event.ready is high. A quiet tick is dropped
// before the queue and sends no word. A waiting output word does not stop the
// front end; only a full queue does.
// Configuration writes on i_cfg are taken every cycle and must be made while
// no tick is in flight. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module flow_totalizer_with_alarms (
    input  logic      i_clk,
    input  logic      i_rst_n,
    flt_in_if.sink    i_tick,
    flt_out_if.source o_event,
    flt_cfg_if.sink   i_cfg
);

    flt_pkg::t_cfg r_cfg;
    flt_pkg::t_rec push_rec, head_rec;
    logic          q_push, q_full, q_pop, q_empty;

    // Register file: accept every write word, ignore unknown indexes.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_ticks   <= 16'd1000;
            r_cfg.debounce_ticks <= 16'd50;
            r_cfg.holdoff_ticks  <= 16'd500;
            r_cfg.warn1          <= 32'hFFFF_FFFF;
            r_cfg.warn2          <= 32'hFFFF_FFFF;
            r_cfg.warn3          <= 32'hFFFF_FFFF;
            r_cfg.limit          <= 32'hFFFF_FFFF;
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                flt_pkg::RegWindowTicks:   r_cfg.window_ticks   <= i_cfg.data[15:0];
                flt_pkg::RegDebounceTicks: r_cfg.debounce_ticks <= i_cfg.data[15:0];
                flt_pkg::RegHoldoffTicks:  r_cfg.holdoff_ticks  <= i_cfg.data[15:0];
                flt_pkg::RegWarn1:         r_cfg.warn1          <= i_cfg.data;
                flt_pkg::RegWarn2:         r_cfg.warn2          <= i_cfg.data;
                flt_pkg::RegWarn3:         r_cfg.warn3          <= i_cfg.data;
                flt_pkg::RegLimit:         r_cfg.limit          <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Front: timers, accumulators and debounce; one tick per cycle while the queue has room.
    flt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (i_tick),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_rec    (push_rec)
    );

    // Queue: decouple tick acceptance from event output.
    flt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_rec),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (head_rec),
        .o_empty (q_empty)
    );

    // Back: threshold ladder and serial event output.
    flt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_data  (head_rec),
        .o_pop     (q_pop),
        .o_event   (o_event)
    );

endmodule

FILE: hdl/flt_checker.sv
// ----------------------------------------------------------------------------
// flt_checker
// Port-level checks on the event output of the flow totalizer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [1:0]  i_kind,
    input logic [2:0]  i_level,
    input logic [31:0] i_wc,
    input logic [16:0] i_wl,
    input logic [31:0] i_total,
    input logic        i_last
);

    logic acc;
    // Set after a flow word that is not the last of its tick.
    logic r_flow_open;

    assign acc = i_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow_open <= 1'b0;
        end else if (acc) begin
            r_flow_open <= (i_kind == flt_pkg::EvFlow) && !i_last;
        end
    end

    `ASSERT_NXT(a_hold, i_valid && !i_ready, i_valid && $stable(i_kind) && $stable(i_total) && $stable(i_last))
    `ASSERT_IMP(a_level, i_valid, (i_kind == flt_pkg::EvThresh) == (i_level != flt_pkg::AlarmNone))
    `ASSERT_IMP(a_press, i_valid && i_kind == flt_pkg::EvPress, i_wc == 32'd0 && i_wl == 17'd0 && i_total == 32'd0 && i_last)
    `ASSERT_IMP(a_thr_order, acc && i_kind == flt_pkg::EvThresh, r_flow_open)

endmodule

bind flow_totalizer_with_alarms flt_checker u_flt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_event.valid),
    .i_ready (o_event.ready),
    .i_kind  (o_event.event_kind),
    .i_level (o_event.alarm_level),
    .i_wc    (o_event.window_count),
    .i_wl    (o_event.window_length),
    .i_total (o_event.total_count),
    .i_last  (o_event.last)
);
